// ----- hdl/feedback_echo_delay_defines.svh -----
// Assertion macros used by the RTL file of the echo block, feedback_echo_delay.sv.
// Every macro samples on the rising edge of aclk and is quiet while aresetn is low.
`ifndef FEEDBACK_ECHO_DELAY_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define FED_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FED_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- hdl/fbecho_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fbecho_pkg;

    // Sequencer that works out the delay length after reset and after a resize.
    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_MUL,
        CALC_DIV,
        CALC_LOAD
    } calc_state_t;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_DELAY_MS    = 2'd0;
    localparam reg_index_t REG_SAMPLE_RATE = 2'd1;
    localparam reg_index_t REG_ECHO_GAIN   = 2'd2;

    localparam int DELAY_MS_W = 10;
    localparam int RATE_W     = 18;
    localparam int GAIN_W     = 9;
    localparam int CFG_DATA_W = 18;
    localparam int GAIN_FRAC  = 8;

    localparam logic [DELAY_MS_W-1:0] DELAY_MS_RESET = 10'd200;
    localparam logic [RATE_W-1:0]     RATE_RESET     = 18'd44100;
    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 9'd128;
    localparam logic [GAIN_W-1:0]     GAIN_UNITY     = 9'd256;

    // Division by 1000 is a shift by 3 followed by a multiply with the
    // reciprocal of 125 scaled by 2**32; it is exact for all 25-bit operands.
    localparam int PROD_W      = DELAY_MS_W + RATE_W;
    localparam int PRE_SHIFT   = 3;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int SCALE_W     = PROD_W - PRE_SHIFT + RECIP_W;
    localparam int QUOT_W      = SCALE_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;

endpackage

`default_nettype wire

// ----- hdl/feedback_echo_delay.sv -----
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample_in
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: sample_out
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One sample is taken per clock cycle while s_axis_tready is high; a result passes
// stage 1 and the output register. The history memory port does one read and one
// write per cycle. After reset and after a delay or rate change the block computes
// the delay length and holds s_axis_tready and cfg_ready low meanwhile. No clearing
// pass runs: entries not yet rewritten since the last resize read as zero. A stalled
// output register still lets one more sample enter the second stage.
`timescale 1ns / 1ps
`default_nettype none
`include "feedback_echo_delay_defines.svh"

module feedback_echo_delay #(
    parameter int MAX_DELAY   = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input samples.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SAMPLE_BITS-1:0] sample_in
    // Output samples.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [SAMPLE_BITS-1:0] sample_out
    // Register writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire fbecho_pkg::reg_index_t               cfg_index,
    input  wire logic [fbecho_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fbecho_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IDX_W   = $clog2(MAX_DELAY);
    localparam int LEN_W   = $clog2(MAX_DELAY + 1);
    localparam int GPROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + 2;

    localparam logic signed [SUM_W-1:0] SMP_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMP_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers. Gains above unity are stored as unity.
    // ------------------------------------------------------------------
    logic [DELAY_MS_W-1:0] delay_ms_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  cfg_acc;
    logic                  resize_req;
    calc_state_t           calc_state_reg;
    calc_state_t           calc_state_next;

    assign cfg_ready = (calc_state_reg == CALC_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;

    // A delay write always resizes; a rate write only when the rate really changes.
    assign resize_req = cfg_acc &&
        ((cfg_index == REG_DELAY_MS) ||
         ((cfg_index == REG_SAMPLE_RATE) && (cfg_data[RATE_W-1:0] != rate_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ms_reg <= DELAY_MS_RESET;
            rate_reg     <= RATE_RESET;
            gain_reg     <= GAIN_RESET;
        end else if (cfg_acc) begin
            unique case (cfg_index)
                REG_DELAY_MS: begin
                    delay_ms_reg <= cfg_data[DELAY_MS_W-1:0];
                end
                REG_SAMPLE_RATE: begin
                    rate_reg <= cfg_data[RATE_W-1:0];
                end
                REG_ECHO_GAIN: begin
                    gain_reg <= (cfg_data[GAIN_W-1:0] > GAIN_UNITY) ? GAIN_UNITY
                                                                     : cfg_data[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Delay length: delay_ms * rate / 1000, clamped to 1 .. MAX_DELAY.
    // CALC_MUL and CALC_DIV each do one multiply, and each result is registered.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]  prod_reg;
    logic [SCALE_W-1:0] recip_prod;
    logic [QUOT_W-1:0]  quot_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_state_reg <= CALC_MUL;
        end else begin
            calc_state_reg <= calc_state_next;
        end
    end

    always_comb begin
        calc_state_next = calc_state_reg;
        unique case (calc_state_reg)
            CALC_IDLE: begin
                if (resize_req) begin
                    calc_state_next = CALC_MUL;
                end
            end
            CALC_MUL: begin
                calc_state_next = CALC_DIV;
            end
            CALC_DIV: begin
                calc_state_next = CALC_LOAD;
            end
            CALC_LOAD: begin
                calc_state_next = CALC_IDLE;
            end
            default: begin
                calc_state_next = CALC_IDLE;
            end
        endcase
    end

    assign recip_prod = SCALE_W'(prod_reg[PROD_W-1:PRE_SHIFT]) * SCALE_W'(RECIP_125);

    always_comb begin
        if (quot_reg == '0) begin
            len_clamped = LEN_W'(1);
        end else if (int'(quot_reg) > MAX_DELAY) begin
            len_clamped = LEN_W'(MAX_DELAY);
        end else begin
            len_clamped = LEN_W'(quot_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_state_reg == CALC_MUL) begin
            prod_reg <= PROD_W'(delay_ms_reg) * PROD_W'(rate_reg);
        end
        if (calc_state_reg == CALC_DIV) begin
            quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // ------------------------------------------------------------------
    // Ring index. The wrap flag tells whether every entry below the length
    // has been rewritten since the last resize; until then reads are zero.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [LEN_W-1:0] idx_inc;
    logic             wrap;
    logic             wrapped_reg;
    logic             s_acc;
    logic             en1;

    assign idx_inc  = LEN_W'(idx_reg) + LEN_W'(1);
    assign wrap     = (idx_inc == len_reg);
    assign idx_next = wrap ? '0 : idx_inc[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_W'(1);
            idx_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else if (calc_state_reg == CALC_LOAD) begin
            len_reg     <= len_clamped;
            idx_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else if (s_acc) begin
            idx_reg     <= idx_next;
            wrapped_reg <= wrapped_reg || wrap;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline. Stage 0 is the transfer, which issues the memory read.
    // Stage 1 holds the sample while the read data arrives, does the
    // multiply-add and writes the result back. The output register follows.
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [IDX_W-1:0]              s1_idx_reg;
    logic                          s1_fwd_reg;
    logic [SAMPLE_BITS-1:0]        s1_fwd_data_reg;
    logic                          s1_hist_ok_reg;
    logic                          m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]        m_data_reg;

    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic [SAMPLE_BITS-1:0]        hist;
    logic signed [GPROD_W-1:0]     gprod;
    logic signed [GPROD_W-1:0]     gscaled;
    logic signed [SUM_W-1:0]       sum_full;
    logic [SAMPLE_BITS-1:0]        sum_sat;
    logic                          ram_we;

    assign en1           = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = (calc_state_reg == CALC_IDLE) && (!s1_valid_reg || en1);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s1_valid_reg && en1;

    // The write from stage 1 lands in the same cycle as a new read, so a
    // read of that entry takes the value being written instead of the memory.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (en1) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_sample_reg   <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            s1_idx_reg      <= idx_reg;
            s1_fwd_reg      <= s1_valid_reg && (s1_idx_reg == idx_reg);
            s1_fwd_data_reg <= sum_sat;
            s1_hist_ok_reg  <= wrapped_reg;
        end
    end

    fbecho_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_idx_reg),
        .wr_data (sum_sat),
        .rd_en   (s_acc),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        if (s1_fwd_reg) begin
            hist = s1_fwd_data_reg;
        end else if (s1_hist_ok_reg) begin
            hist = ram_rdata;
        end else begin
            hist = '0;
        end
    end

    // The arithmetic shift rounds the scaled history toward minus infinity.
    assign gprod    = $signed(hist) * $signed({1'b0, gain_reg});
    assign gscaled  = gprod >>> GAIN_FRAC;
    assign sum_full = SUM_W'(s1_sample_reg) + $signed(gscaled[SUM_W-1:0]);

    always_comb begin
        if (sum_full > SMP_MAX) begin
            sum_sat = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (sum_full < SMP_MIN) begin
            sum_sat = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            sum_sat = sum_full[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en1) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            m_data_reg <= sum_sat;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = TDATA_W'(m_data_reg);

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `FED_ASSERT_IMPL(a_idx_below_len, calc_state_reg == CALC_IDLE, LEN_W'(idx_reg) < len_reg, "ring index at or beyond delay length")
    `FED_ASSERT_IMPL(a_len_legal, calc_state_reg == CALC_IDLE, (len_reg != '0) && (int'(len_reg) <= MAX_DELAY), "delay length out of range")
    `FED_ASSERT_NEXT(a_stage_drains, s1_valid_reg && en1, m_tvalid_reg, "stage 1 result did not reach the output register")
    `FED_ASSERT_NEXT(a_wrap_marks, s_acc && wrap, wrapped_reg && (idx_reg == '0), "ring wrap not recorded")

endmodule

`default_nettype wire

// ----- hdl/fbecho_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbecho_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
